FILE: rtl/core/ssl_pkg.sv
`timescale 1ns / 1ps

package ssl_pkg;

    // Sample store geometry.
    localparam int BANK_DEPTH    = 16384;
    localparam int BANK_AW       = $clog2(BANK_DEPTH);
    localparam int RAM_DEPTH     = 2 * BANK_DEPTH;
    localparam int SAMPLE_W      = 8;

    // Phase accumulator: integer part of the phase followed by the fraction.
    localparam int FRACTION_BITS = 12;
    localparam int INT_W         = 15;
    localparam int PHASE_W       = INT_W + FRACTION_BITS;

    // Field widths.
    localparam int THR_W         = 12;
    localparam int LEN_W         = 15;
    localparam int LEVEL_W       = 12;
    localparam int RATE_W        = 12;
    localparam int SLICE_W       = 5;
    localparam int LOAD_ADDR_W   = 14;
    localparam int AUDIO_W       = 12;
    localparam int AUDIO_SHIFT   = 4;

    // A slice is one sixteenth of the bank length.
    localparam int SLICE_SHIFT   = 4;
    localparam int PROD_W        = SLICE_W + LEN_W - SLICE_SHIFT;

    // Bank length clamp.
    localparam int LEN_MIN       = 2;
    localparam int LEN_CAP       = (1 << LEN_W) - 1;
    localparam int LEN_MAX       = (BANK_DEPTH < LEN_CAP) ? BANK_DEPTH : LEN_CAP;

    // Register reset values.
    localparam int THR_RESET     = 2048;
    localparam int LEN_RESET     = 16384;

    // Configuration port.
    localparam int APB_AW        = 4;
    localparam int APB_DW        = 32;
    localparam int REG_IDX_W     = APB_AW - 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_LEN_A     = 2'd1,
        REG_LEN_B     = 2'd2
    } t_reg_idx;

    typedef enum logic {
        ACT_PLAY = 1'b0,
        ACT_LOAD = 1'b1
    } t_action;

    typedef enum logic {
        BANK_A = 1'b0,
        BANK_B = 1'b1
    } t_bank;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [LEN_W-1:0] len_a;
        logic [LEN_W-1:0] len_b;
    } t_cfg;

endpackage

FILE: rtl/core/ssl_intf.sv
`timescale 1ns / 1ps

interface ssl_in_if;
    import ssl_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   action;
    logic                   bank_select;
    logic [LEVEL_W-1:0]     trigger_level;
    logic [RATE_W-1:0]      rate;
    logic [SLICE_W-1:0]     slice;
    logic [LOAD_ADDR_W-1:0] load_address;
    logic [SAMPLE_W-1:0]    load_data;

    modport source (
        output valid, action, bank_select, trigger_level, rate, slice,
               load_address, load_data,
        input  ready
    );

    modport sink (
        input  valid, action, bank_select, trigger_level, rate, slice,
               load_address, load_data,
        output ready
    );
endinterface

interface ssl_out_if;
    import ssl_pkg::*;

    logic               valid;
    logic               ready;
    logic [AUDIO_W-1:0] audio_out;

    modport source (
        output valid, audio_out,
        input  ready
    );

    modport sink (
        input  valid, audio_out,
        output ready
    );
endinterface

FILE: rtl/core/ssl_ram.sv
`timescale 1ns / 1ps

module ssl_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ssl_cfg.sv
`timescale 1ns / 1ps

module ssl_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssl_pkg::APB_AW-1:0] paddr,
    input  logic [ssl_pkg::APB_DW-1:0] pwdata,
    output logic [ssl_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output ssl_pkg::t_cfg              o_cfg
);
    import ssl_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_THRESHOLD: n_cfg.threshold = pwdata[THR_W-1:0];
                REG_LEN_A:     n_cfg.len_a     = pwdata[LEN_W-1:0];
                REG_LEN_B:     n_cfg.len_b     = pwdata[LEN_W-1:0];
                default:       n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= THR_W'(THR_RESET);
            r_cfg.len_a     <= LEN_W'(LEN_RESET);
            r_cfg.len_b     <= LEN_W'(LEN_RESET);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_THRESHOLD: prdata = APB_DW'(r_cfg.threshold);
            REG_LEN_A:     prdata = APB_DW'(r_cfg.len_a);
            REG_LEN_B:     prdata = APB_DW'(r_cfg.len_b);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/ssl_phase.sv
`timescale 1ns / 1ps

module ssl_phase (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tick,
    input  logic                        i_bank,
    input  logic [ssl_pkg::LEVEL_W-1:0] i_level,
    input  logic [ssl_pkg::RATE_W-1:0]  i_rate,
    input  logic [ssl_pkg::SLICE_W-1:0] i_slice,
    input  ssl_pkg::t_cfg               i_cfg,
    output logic [ssl_pkg::BANK_AW-1:0] o_idx
);
    import ssl_pkg::*;

    logic [PHASE_W-1:0]       r_phase;
    logic [PHASE_W-1:0]       n_phase;
    logic                     r_trig_high;
    logic                     n_trig_high;

    logic [LEN_W-1:0]         len_raw;
    logic [LEN_W-1:0]         len_eff;
    logic                     trig_ge;
    logic                     restart;
    logic [PROD_W-1:0]        restart_pos;
    logic [INT_W-1:0]         base;
    logic [INT_W-1:0]         once;
    logic                     wrap1;
    logic                     wrap2;
    logic [INT_W-1:0]         idx;
    logic [FRACTION_BITS-1:0] frac;
    logic [31:0]              idx_wide;

    // Effective length of the selected bank, clamped to the usable range.
    assign len_raw = (i_bank == BANK_B) ? i_cfg.len_b : i_cfg.len_a;

    always_comb begin
        if (32'(len_raw) < LEN_MIN) begin
            len_eff = LEN_W'(LEN_MIN);
        end else if (32'(len_raw) > LEN_MAX) begin
            len_eff = LEN_W'(LEN_MAX);
        end else begin
            len_eff = len_raw;
        end
    end

    assign trig_ge     = (i_level >= i_cfg.threshold);
    assign restart     = trig_ge && !r_trig_high;
    assign restart_pos = PROD_W'(i_slice) * PROD_W'(len_eff >> SLICE_SHIFT);

    assign base  = restart ? restart_pos[INT_W-1:0] : r_phase[PHASE_W-1:FRACTION_BITS];
    assign wrap1 = (base >= len_eff);
    assign once  = base - len_eff;
    assign wrap2 = (once >= len_eff);

    always_comb begin
        if (!wrap1) begin
            idx = base;
        end else if (wrap2) begin
            idx = '0;
        end else begin
            idx = once;
        end
    end

    // The fraction is dropped on a restart and on a wrap.
    assign frac = (restart || wrap1) ? '0 : r_phase[FRACTION_BITS-1:0];

    assign n_phase     = i_tick ? ({idx, frac} + PHASE_W'({i_rate, 1'b0})) : r_phase;
    assign n_trig_high = i_tick ? trig_ge : r_trig_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_trig_high <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_trig_high <= n_trig_high;
        end
    end

    assign idx_wide = 32'(idx);
    assign o_idx    = idx_wide[BANK_AW-1:0];

    a_idx_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick |-> (idx < len_eff))
        else $error("sample index not below the bank length");

    a_idle_holds_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tick |=> ($stable(r_phase) && $stable(r_trig_high)))
        else $error("phase changed without a tick");

    a_low_clears_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tick && !trig_ge) |=> !r_trig_high)
        else $error("trigger state not cleared by a low level");

endmodule

FILE: rtl/core/sliced_sample_looper.sv
// Loop player over two 8-bit sample banks held in one synchronous RAM that reset leaves alone.
// Throughput: one beat per cycle, play or load; the input stalls only when the RAM read
// register and the output register both hold results and o_out is not ready.
// Path: an accepted play beat's result passes through the RAM read register and then the
// output register, which drives o_out.valid. The phase updates at the accept edge.
// Reset (synchronous, active low) clears phase, trigger and valids, loads register defaults.
`timescale 1ns / 1ps

module sliced_sample_looper (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ssl_in_if.sink                     i_in,
    ssl_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssl_pkg::APB_AW-1:0] paddr,
    input  logic [ssl_pkg::APB_DW-1:0] pwdata,
    output logic [ssl_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import ssl_pkg::*;

    localparam int RAM_AW = $clog2(RAM_DEPTH);
    localparam int ADDR_X = (LOAD_ADDR_W > BANK_AW) ? LOAD_ADDR_W : BANK_AW;

    t_cfg                cfg;
    logic                in_beat;
    logic                tick;
    logic                load;
    logic                load_in_range;
    logic [ADDR_X-1:0]   load_addr_x;
    logic [BANK_AW-1:0]  play_idx;
    logic [SAMPLE_W-1:0] rd_data;

    // Result path: the RAM read register is the first stage, then the output register.
    logic                r_s1_v;
    logic                n_s1_v;
    logic                r_o_v;
    logic                n_o_v;
    logic [AUDIO_W-1:0]  r_o_data;
    logic                s1_move;

    // Configuration registers.
    ssl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The sample in the read register moves on when the output register is
    // empty or being emptied; a new beat is taken when the read register is
    // free or moving on in this cycle.
    assign s1_move     = r_s1_v && (!r_o_v || o_out.ready);
    assign i_in.ready  = !r_s1_v || s1_move;
    assign in_beat     = i_in.valid && i_in.ready;
    assign tick        = in_beat && (t_action'(i_in.action) == ACT_PLAY);
    assign load        = in_beat && (t_action'(i_in.action) == ACT_LOAD);

    // Loads beyond the bank depth are dropped.
    assign load_in_range = (32'(i_in.load_address) < BANK_DEPTH);
    assign load_addr_x   = ADDR_X'(i_in.load_address);

    // Phase accumulator, trigger edge detect and index wrap.
    ssl_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick),
        .i_bank  (i_in.bank_select),
        .i_level (i_in.trigger_level),
        .i_rate  (i_in.rate),
        .i_slice (i_in.slice),
        .i_cfg   (cfg),
        .o_idx   (play_idx)
    );

    // Both banks share one RAM; the bank select is the top address bit.
    // A load writes at its edge and any later play beat reads after that
    // edge, so no forwarding is needed.
    ssl_ram #(
        .DEPTH (RAM_DEPTH),
        .WIDTH (SAMPLE_W),
        .AW    (RAM_AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (load && load_in_range),
        .i_waddr ({i_in.bank_select, load_addr_x[BANK_AW-1:0]}),
        .i_wdata (i_in.load_data),
        .i_re    (tick),
        .i_raddr ({i_in.bank_select, play_idx}),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_s1_v = r_s1_v;
        if (tick) begin
            n_s1_v = 1'b1;
        end else if (s1_move) begin
            n_s1_v = 1'b0;
        end
    end

    always_comb begin
        n_o_v = r_o_v;
        if (s1_move) begin
            n_o_v = 1'b1;
        end else if (o_out.ready) begin
            n_o_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            r_s1_v <= n_s1_v;
            r_o_v  <= n_o_v;
        end
    end

    // Output payload: the played sample shifted up by four bits.
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_data <= AUDIO_W'({rd_data, AUDIO_SHIFT'(0)});
        end
    end

    assign o_out.valid     = r_o_v;
    assign o_out.audio_out = r_o_data;

    a_no_s1_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !s1_move) |-> !tick)
        else $error("read register overwritten before it moved on");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !r_s1_v) |=> !r_s1_v)
        else $error("load beat produced a result");

    a_tick_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick && !r_o_v && !r_s1_v) |=> ##1 r_o_v)
        else $error("play beat did not reach the output register");

endmodule
